// File: design/acsc_pkg.sv
// shared types, constants and digit functions for the alarm clock set-mode controller
package acsc_pkg;

    typedef enum logic [5:0] {
        MODE_NORMAL        = 6'b000001,
        MODE_ALARM_VIEW    = 6'b000010,
        MODE_SET_HOUR      = 6'b000100,
        MODE_SET_MINUTE    = 6'b001000,
        MODE_SET_WAKE_HOUR = 6'b010000,
        MODE_SET_WAKE_MIN  = 6'b100000
    } t_mode;

    localparam logic [2:0] CODE_NORMAL        = 3'd0;
    localparam logic [2:0] CODE_ALARM_VIEW    = 3'd1;
    localparam logic [2:0] CODE_SET_HOUR      = 3'd2;
    localparam logic [2:0] CODE_SET_MINUTE    = 3'd3;
    localparam logic [2:0] CODE_SET_WAKE_HOUR = 3'd4;
    localparam logic [2:0] CODE_SET_WAKE_MIN  = 3'd5;

    // bit positions in the rtc write request word
    localparam int WR_HOUR      = 0;
    localparam int WR_MINUTE    = 1;
    localparam int WR_WAKE_HOUR = 2;
    localparam int WR_WAKE_MIN  = 3;
    localparam int WR_ARM       = 4;
    localparam int WR_DISARM    = 5;
    localparam int WR_CLEAR     = 6;
    localparam int WR_BITS      = 7;

    localparam logic [7:0] SEG_BLANK = 8'hFF;

    typedef struct packed {
        t_mode                mode;
        logic                 buzzer;
        logic                 armed;
        logic [WR_BITS-1:0]   writes;
    } t_ctrl;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        case (m)
            MODE_ALARM_VIEW:    c = CODE_ALARM_VIEW;
            MODE_SET_HOUR:      c = CODE_SET_HOUR;
            MODE_SET_MINUTE:    c = CODE_SET_MINUTE;
            MODE_SET_WAKE_HOUR: c = CODE_SET_WAKE_HOUR;
            MODE_SET_WAKE_MIN:  c = CODE_SET_WAKE_MIN;
            default:            c = CODE_NORMAL;
        endcase
        return c;
    endfunction

    // tens in [7:4], units in [3:0], for values up to 63
    function automatic logic [7:0] split_dec(input logic [5:0] v);
        logic [3:0] t;
        logic [5:0] base;
        if (v >= 6'd60) begin
            t = 4'd6; base = 6'd60;
        end else if (v >= 6'd50) begin
            t = 4'd5; base = 6'd50;
        end else if (v >= 6'd40) begin
            t = 4'd4; base = 6'd40;
        end else if (v >= 6'd30) begin
            t = 4'd3; base = 6'd30;
        end else if (v >= 6'd20) begin
            t = 4'd2; base = 6'd20;
        end else if (v >= 6'd10) begin
            t = 4'd1; base = 6'd10;
        end else begin
            t = 4'd0; base = 6'd0;
        end
        return {t, 4'(v - base)};
    endfunction

    function automatic logic [5:0] next_hour_bcd(input logic [4:0] h);
        logic [4:0] n;
        logic [7:0] d;
        n = (h < 5'd23) ? 5'(h + 5'd1) : 5'd0;
        d = split_dec({1'b0, n});
        return {d[5:4], d[3:0]};
    endfunction

    function automatic logic [6:0] next_minute_bcd(input logic [5:0] m);
        logic [5:0] n;
        logic [7:0] d;
        n = (m < 6'd59) ? 6'(m + 6'd1) : 6'd0;
        d = split_dec(n);
        return {d[6:4], d[3:0]};
    endfunction

    function automatic logic [7:0] seg_lead(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h84;
            4'd1:    s = 8'hCF;
            4'd2:    s = 8'hA8;
            4'd3:    s = 8'h89;
            4'd4:    s = 8'hC3;
            4'd5:    s = 8'h91;
            4'd6:    s = 8'h90;
            4'd7:    s = 8'h8F;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h81;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] seg_third(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h82;
            4'd1:    s = 8'hCF;
            4'd2:    s = 8'hA1;
            4'd3:    s = 8'h89;
            4'd4:    s = 8'hCC;
            4'd5:    s = 8'h98;
            4'd6:    s = 8'h90;
            4'd7:    s = 8'h8F;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h88;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] seg_last(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h82;
            4'd1:    s = 8'h9F;
            4'd2:    s = 8'hA1;
            4'd3:    s = 8'h89;
            4'd4:    s = 8'h9C;
            4'd5:    s = 8'hC8;
            4'd6:    s = 8'hC0;
            4'd7:    s = 8'h8F;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h88;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

// File: design/acsc_ctrl.sv
// mode, alarm arm, ringing and buzzer state with the button decode
module acsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_step,
    input  logic            i_inc,
    input  logic            i_mode_btn,
    input  logic            i_fired,
    output acsc_pkg::t_ctrl o_ctrl
);

    acsc_pkg::t_mode r_mode, n_mode;
    acsc_pkg::t_mode mode_inc;
    logic r_armed, n_armed;
    logic r_ringing, n_ringing;
    logic r_buzz, n_buzz;
    logic [acsc_pkg::WR_BITS-1:0] wr;
    logic ring_now;

    always_comb begin
        wr       = '0;
        mode_inc = r_mode;
        if (i_inc) begin
            case (r_mode)
                acsc_pkg::MODE_NORMAL:        mode_inc = acsc_pkg::MODE_ALARM_VIEW;
                acsc_pkg::MODE_ALARM_VIEW:    mode_inc = acsc_pkg::MODE_NORMAL;
                acsc_pkg::MODE_SET_HOUR:      wr[acsc_pkg::WR_HOUR] = 1'b1;
                acsc_pkg::MODE_SET_MINUTE:    wr[acsc_pkg::WR_MINUTE] = 1'b1;
                acsc_pkg::MODE_SET_WAKE_HOUR: wr[acsc_pkg::WR_WAKE_HOUR] = 1'b1;
                acsc_pkg::MODE_SET_WAKE_MIN:  wr[acsc_pkg::WR_WAKE_MIN] = 1'b1;
                default: ;
            endcase
        end

        // mode button acts on the mode left by the increment button
        n_mode  = mode_inc;
        n_armed = r_armed;
        if (i_mode_btn) begin
            case (mode_inc)
                acsc_pkg::MODE_NORMAL:        n_mode = acsc_pkg::MODE_SET_HOUR;
                acsc_pkg::MODE_SET_HOUR:      n_mode = acsc_pkg::MODE_SET_MINUTE;
                acsc_pkg::MODE_SET_MINUTE:    n_mode = acsc_pkg::MODE_NORMAL;
                acsc_pkg::MODE_ALARM_VIEW:    n_mode = acsc_pkg::MODE_SET_WAKE_HOUR;
                acsc_pkg::MODE_SET_WAKE_HOUR: n_mode = acsc_pkg::MODE_SET_WAKE_MIN;
                acsc_pkg::MODE_SET_WAKE_MIN: begin
                    n_mode  = acsc_pkg::MODE_ALARM_VIEW;
                    n_armed = !r_armed;
                    if (r_armed) begin
                        wr[acsc_pkg::WR_DISARM] = 1'b1;
                    end else begin
                        wr[acsc_pkg::WR_ARM] = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        ring_now  = r_ringing || i_fired;
        n_ringing = ring_now && !(i_inc || i_mode_btn);
        n_buzz    = ring_now && !r_buzz;
        if (ring_now && (i_inc || i_mode_btn)) begin
            wr[acsc_pkg::WR_CLEAR] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= acsc_pkg::MODE_NORMAL;
            r_armed   <= 1'b0;
            r_ringing <= 1'b0;
            r_buzz    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_armed <= i_cfg_wr_data;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_armed   <= n_armed;
            r_ringing <= n_ringing;
            r_buzz    <= n_buzz;
        end
    end

    assign o_ctrl.mode   = n_mode;
    assign o_ctrl.buzzer = n_buzz;
    assign o_ctrl.armed  = n_armed;
    assign o_ctrl.writes = wr;

endmodule

// File: design/acsc_disp.sv
// segment encoding with per-mode blanking and the incremented bcd values
module acsc_disp (
    input  acsc_pkg::t_mode i_mode,
    input  logic [4:0]      i_clock_hour,
    input  logic [5:0]      i_clock_minute,
    input  logic [4:0]      i_wake_hour,
    input  logic [5:0]      i_wake_minute,
    output logic [31:0]     o_segment_codes,
    output logic [5:0]      o_next_clock_hour_bcd,
    output logic [6:0]      o_next_clock_minute_bcd,
    output logic [5:0]      o_next_wake_hour_bcd,
    output logic [6:0]      o_next_wake_minute_bcd
);

    logic       show_wake, show_h, show_m;
    logic [4:0] hv;
    logic [5:0] mv;
    logic [7:0] hd, md;
    logic [7:0] d1, d2, d3, d4;

    always_comb begin
        show_wake = 1'b0;
        show_h    = 1'b1;
        show_m    = 1'b1;
        case (i_mode)
            acsc_pkg::MODE_ALARM_VIEW:    show_wake = 1'b1;
            acsc_pkg::MODE_SET_HOUR:      show_m = 1'b0;
            acsc_pkg::MODE_SET_MINUTE:    show_h = 1'b0;
            acsc_pkg::MODE_SET_WAKE_HOUR: begin
                show_wake = 1'b1;
                show_m    = 1'b0;
            end
            acsc_pkg::MODE_SET_WAKE_MIN: begin
                show_wake = 1'b1;
                show_h    = 1'b0;
            end
            default: ;
        endcase

        hv = show_wake ? i_wake_hour : i_clock_hour;
        mv = show_wake ? i_wake_minute : i_clock_minute;
        hd = acsc_pkg::split_dec({1'b0, hv});
        md = acsc_pkg::split_dec(mv);

        d1 = show_h ? acsc_pkg::seg_lead(hd[7:4]) : acsc_pkg::SEG_BLANK;
        d2 = show_h ? acsc_pkg::seg_lead(hd[3:0]) : acsc_pkg::SEG_BLANK;
        d3 = show_m ? acsc_pkg::seg_third(md[7:4]) : acsc_pkg::SEG_BLANK;
        d4 = show_m ? acsc_pkg::seg_last(md[3:0]) : acsc_pkg::SEG_BLANK;
    end

    assign o_segment_codes         = {d4, d3, d2, d1};
    assign o_next_clock_hour_bcd   = acsc_pkg::next_hour_bcd(i_clock_hour);
    assign o_next_clock_minute_bcd = acsc_pkg::next_minute_bcd(i_clock_minute);
    assign o_next_wake_hour_bcd    = acsc_pkg::next_hour_bcd(i_wake_hour);
    assign o_next_wake_minute_bcd  = acsc_pkg::next_minute_bcd(i_wake_minute);

endmodule

// File: design/alarm_clock_setting_controller.sv
// top level: input register, tick step logic and result register
// Alarm clock set-mode controller.
// Input channel (i_valid/o_ready) carries one button-poll tick: button levels,
// the alarm event, the blink phase and the clock and alarm times.
// Output channel (o_valid/i_ready) carries one result per tick: segment bytes,
// mode, colon, buzzer, armed status, rtc write requests and bcd values.
// A transferred tick is held in the input register, passes the mode/ringing
// step logic, and lands in the result register, which drives o_valid.
// Throughput is one tick per cycle while i_ready stays high; the only feedback
// is the loop through the mode, armed, ringing and buzzer registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more tick, then o_ready drops until the result drains.
// i_cfg_wr_en loads the armed state from i_cfg_wr_data; write it while idle.
// Synchronous reset puts the block in normal mode, disarmed, silent, empty.
module alarm_clock_setting_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_inc_pressed,
    input  logic        i_mode_pressed,
    input  logic        i_alarm_fired,
    input  logic        i_blink_phase,
    input  logic [4:0]  i_clock_hour,
    input  logic [5:0]  i_clock_minute,
    input  logic [4:0]  i_wake_hour,
    input  logic [5:0]  i_wake_minute,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_segment_codes,
    output logic [2:0]  o_mode_now,
    output logic        o_colon_led,
    output logic        o_buzzer,
    output logic        o_alarm_enabled,
    output logic [6:0]  o_rtc_writes,
    output logic [5:0]  o_next_clock_hour_bcd,
    output logic [6:0]  o_next_clock_minute_bcd,
    output logic [5:0]  o_next_wake_hour_bcd,
    output logic [6:0]  o_next_wake_minute_bcd
);

    logic       r_in_vld;
    logic       r_inc, r_mode_btn, r_fired, r_blink;
    logic [4:0] r_ch, r_wh;
    logic [5:0] r_cm, r_wm;

    logic        r_out_vld;
    logic [31:0] r_seg;
    logic [2:0]  r_mode_code;
    logic        r_colon, r_buzzer, r_armed_out;
    logic [6:0]  r_writes;
    logic [5:0]  r_nch, r_nwh;
    logic [6:0]  r_ncm, r_nwm;

    logic            out_free, step, in_xfer;
    acsc_pkg::t_ctrl ctrl;
    logic [31:0]     seg;
    logic [5:0]      nch, nwh;
    logic [6:0]      ncm, nwm;

    assign out_free = !r_out_vld || i_ready;
    assign step     = r_in_vld && out_free;
    assign o_ready  = !r_in_vld || out_free;
    assign in_xfer  = i_valid && o_ready;

    acsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (step),
        .i_inc         (r_inc),
        .i_mode_btn    (r_mode_btn),
        .i_fired       (r_fired),
        .o_ctrl        (ctrl)
    );

    acsc_disp u_disp (
        .i_mode                  (ctrl.mode),
        .i_clock_hour            (r_ch),
        .i_clock_minute          (r_cm),
        .i_wake_hour             (r_wh),
        .i_wake_minute           (r_wm),
        .o_segment_codes         (seg),
        .o_next_clock_hour_bcd   (nch),
        .o_next_clock_minute_bcd (ncm),
        .o_next_wake_hour_bcd    (nwh),
        .o_next_wake_minute_bcd  (nwm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_inc      <= i_inc_pressed;
            r_mode_btn <= i_mode_pressed;
            r_fired    <= i_alarm_fired;
            r_blink    <= i_blink_phase;
            r_ch       <= i_clock_hour;
            r_cm       <= i_clock_minute;
            r_wh       <= i_wake_hour;
            r_wm       <= i_wake_minute;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_seg       <= seg;
            r_mode_code <= acsc_pkg::mode_code(ctrl.mode);
            r_colon     <= r_blink && (ctrl.mode == acsc_pkg::MODE_NORMAL);
            r_buzzer    <= ctrl.buzzer;
            r_armed_out <= ctrl.armed;
            r_writes    <= ctrl.writes;
            r_nch       <= nch;
            r_ncm       <= ncm;
            r_nwh       <= nwh;
            r_nwm       <= nwm;
        end
    end

    assign o_valid                 = r_out_vld;
    assign o_segment_codes         = r_seg;
    assign o_mode_now              = r_mode_code;
    assign o_colon_led             = r_colon;
    assign o_buzzer                = r_buzzer;
    assign o_alarm_enabled         = r_armed_out;
    assign o_rtc_writes            = r_writes;
    assign o_next_clock_hour_bcd   = r_nch;
    assign o_next_clock_minute_bcd = r_ncm;
    assign o_next_wake_hour_bcd    = r_nwh;
    assign o_next_wake_minute_bcd  = r_nwm;

endmodule

// File: design/acsc_checker.sv
// port-level checks for the alarm clock set-mode controller, bound to the top level
module acsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_segment_codes,
    input logic [2:0]  o_mode_now,
    input logic        o_colon_led,
    input logic        o_alarm_enabled,
    input logic [6:0]  o_rtc_writes
);

    // colon lamp only lights in normal mode
    a_colon_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_colon_led |-> o_mode_now == acsc_pkg::CODE_NORMAL)
        else $error("colon lit outside normal mode");

    // arm request only when leaving alarm minute set, and leaves the alarm armed
    a_arm_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rtc_writes[acsc_pkg::WR_ARM]
        |-> o_alarm_enabled && o_mode_now == acsc_pkg::CODE_ALARM_VIEW)
        else $error("arm request with wrong status or mode");

    a_disarm_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rtc_writes[acsc_pkg::WR_DISARM]
        |-> !o_alarm_enabled && !o_rtc_writes[acsc_pkg::WR_ARM])
        else $error("disarm request with wrong status");

    // hour set modes blank the minute digits
    a_hour_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_mode_now == acsc_pkg::CODE_SET_HOUR ||
                    o_mode_now == acsc_pkg::CODE_SET_WAKE_HOUR)
        |-> o_segment_codes[31:16] == {acsc_pkg::SEG_BLANK, acsc_pkg::SEG_BLANK})
        else $error("minute digits not blank in hour set mode");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_segment_codes)
                                && $stable(o_rtc_writes))
        else $error("stalled result changed");

endmodule

bind alarm_clock_setting_controller acsc_checker u_acsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_segment_codes (o_segment_codes),
    .o_mode_now      (o_mode_now),
    .o_colon_led     (o_colon_led),
    .o_alarm_enabled (o_alarm_enabled),
    .o_rtc_writes    (o_rtc_writes)
);
